/* sv/jdqt_pkg.sv */
// Shared constants and codes for the JPEG quantization-table segment parser.
`default_nettype none

package jdqt_pkg;

  // Table geometry.
  localparam int TABLE_ENTRIES = 64;
  localparam int NUM_TABLES    = 4;
  localparam int HEADER_BYTES  = 3;

  // Field widths that follow from the table geometry.
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int TID_W = $clog2(NUM_TABLES);

  // Smallest legal segment length for 8-bit and 16-bit tables.
  localparam logic [15:0] NEED_NARROW = 16'(HEADER_BYTES + TABLE_ENTRIES);
  localparam logic [15:0] NEED_WIDE   = 16'(HEADER_BYTES + 2 * TABLE_ENTRIES);

  // Input command codes.
  typedef enum logic {
    CMD_BYTE  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  // Error codes reported on the byte that caused the error.
  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_PRECISION   = 3'd1,
    ERR_DESTINATION = 3'd2,
    ERR_DUPLICATE   = 3'd3,
    ERR_SHORT       = 3'd4
  } err_t;

endpackage

`default_nettype wire

/* sv/jpeg_dqt_segment_parser.sv */
// Top level of the JPEG quantization-table (DQT) segment parser.
// The parser takes one segment byte per transfer, starting at the two-byte
// big-endian length, and returns exactly one result per input transfer:
// a completed table entry (table, index, value), the end-of-segment flag,
// an error code on the byte that raised it, and the halted flag. Every
// input transfer is handled by the combinational parse logic, and its
// result is registered in one output register, so the block sustains
// one byte per clock as long as the output side does not stall. While that
// register holds a result that is stalled, the input is stalled too; a
// result taken in the same cycle frees it for the next byte. After an error
// all bytes give an empty result with halted set until a clear command,
// which also marks every table empty.
`default_nettype none

module jpeg_dqt_segment_parser (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Input channel.
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      command,
  input  wire logic [7:0]                data_byte,
  // Result channel.
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           entry_valid,
  output logic [jdqt_pkg::TID_W-1:0]     table_id,
  output logic [jdqt_pkg::IDX_W-1:0]     entry_index,
  output logic [15:0]                    entry_value,
  output logic                           segment_done,
  output jdqt_pkg::err_t                 error_code,
  output logic                           halted
);

  import jdqt_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_HEADER  = 3'd2,
    PH_ENTRIES = 3'd3,
    PH_SKIP    = 3'd4
  } phase_t;

  localparam logic [IDX_W:0] LAST_NARROW = (IDX_W + 1)'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W:0] LAST_WIDE   = (IDX_W + 1)'(2 * TABLE_ENTRIES - 1);

  // Parse state.
  phase_t              phase, phase_next;
  logic [15:0]         segment_length, segment_length_next;
  logic [15:0]         bytes_seen, bytes_seen_next;
  logic [7:0]          pending_high_byte, pending_high_byte_next;
  logic                wide_entries, wide_entries_next;
  logic [TID_W-1:0]    current_table, current_table_next;
  logic [NUM_TABLES-1:0] tables_loaded, tables_loaded_next;
  logic                error_halt, error_halt_next;

  // Result of the byte being accepted.
  logic                res_entry_valid;
  logic [TID_W-1:0]    res_table_id;
  logic [IDX_W-1:0]    res_entry_index;
  logic [15:0]         res_entry_value;
  logic                res_segment_done;
  err_t                res_error_code;

  // Header and entry decode.
  logic [3:0]          prec;
  logic [3:0]          dest;
  logic [IDX_W:0]      entry_pos;
  logic [IDX_W:0]      entry_last;
  logic                accept;

  // The output register frees up when empty or when its result is taken.
  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign prec       = data_byte[7:4];
  assign dest       = data_byte[3:0];
  assign entry_pos  = (IDX_W + 1)'(bytes_seen - 16'(HEADER_BYTES));
  assign entry_last = wide_entries ? LAST_WIDE : LAST_NARROW;

  // Next state and result for one segment byte or command.
  always_comb begin
    phase_next             = phase;
    segment_length_next    = segment_length;
    bytes_seen_next        = bytes_seen;
    pending_high_byte_next = pending_high_byte;
    wide_entries_next      = wide_entries;
    current_table_next     = current_table;
    tables_loaded_next     = tables_loaded;
    error_halt_next        = error_halt;

    res_entry_valid  = 1'b0;
    res_table_id     = '0;
    res_entry_index  = '0;
    res_entry_value  = '0;
    res_segment_done = 1'b0;
    res_error_code   = ERR_NONE;

    if (command == CMD_CLEAR) begin
      phase_next             = PH_LEN_HI;
      segment_length_next    = '0;
      bytes_seen_next        = '0;
      pending_high_byte_next = '0;
      wide_entries_next      = 1'b0;
      current_table_next     = '0;
      tables_loaded_next     = '0;
      error_halt_next        = 1'b0;
    end else if (!error_halt) begin
      case (phase)
        PH_LEN_HI: begin
          pending_high_byte_next = data_byte;
          bytes_seen_next        = 16'd1;
          phase_next             = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          segment_length_next = {pending_high_byte, data_byte};
          bytes_seen_next     = 16'd2;
          phase_next          = PH_HEADER;
        end
        PH_HEADER: begin
          // Checks in priority order; the first failing one wins.
          if (prec > 4'd1) begin
            res_error_code = ERR_PRECISION;
          end else if (dest >= 4'(NUM_TABLES)) begin
            res_error_code = ERR_DESTINATION;
          end else if (tables_loaded[dest[TID_W-1:0]]) begin
            res_error_code = ERR_DUPLICATE;
          end else if (segment_length < (prec[0] ? NEED_WIDE : NEED_NARROW)) begin
            res_error_code = ERR_SHORT;
          end

          if (res_error_code != ERR_NONE) begin
            error_halt_next = 1'b1;
          end else begin
            tables_loaded_next[dest[TID_W-1:0]] = 1'b1;
            wide_entries_next  = prec[0];
            current_table_next = dest[TID_W-1:0];
            bytes_seen_next    = 16'(HEADER_BYTES);
            phase_next         = PH_ENTRIES;
          end
        end
        PH_ENTRIES: begin
          bytes_seen_next = bytes_seen + 16'd1;
          if (wide_entries && !entry_pos[0]) begin
            pending_high_byte_next = data_byte;
          end else begin
            res_entry_valid = 1'b1;
            res_table_id    = current_table;
            if (wide_entries) begin
              res_entry_index = entry_pos[IDX_W:1];
              res_entry_value = {pending_high_byte, data_byte};
            end else begin
              res_entry_index = entry_pos[IDX_W-1:0];
              res_entry_value = {8'd0, data_byte};
            end
          end
          // After the last entry byte, finish or skip to the length.
          if (entry_pos >= entry_last) begin
            if (bytes_seen_next == segment_length) begin
              res_segment_done = 1'b1;
              phase_next       = PH_LEN_HI;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          bytes_seen_next = bytes_seen + 16'd1;
          if (bytes_seen_next == segment_length) begin
            res_segment_done = 1'b1;
            phase_next       = PH_LEN_HI;
          end
        end
        default: begin
          phase_next             = PH_LEN_HI;
          segment_length_next    = '0;
          bytes_seen_next        = '0;
          pending_high_byte_next = '0;
          wide_entries_next      = 1'b0;
          current_table_next     = '0;
        end
      endcase
    end
  end

  // State and output register, both loaded on an input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_LEN_HI;
      segment_length    <= '0;
      bytes_seen        <= '0;
      pending_high_byte <= '0;
      wide_entries      <= 1'b0;
      current_table     <= '0;
      tables_loaded     <= '0;
      error_halt        <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (accept) begin
        phase             <= phase_next;
        segment_length    <= segment_length_next;
        bytes_seen        <= bytes_seen_next;
        pending_high_byte <= pending_high_byte_next;
        wide_entries      <= wide_entries_next;
        current_table     <= current_table_next;
        tables_loaded     <= tables_loaded_next;
        error_halt        <= error_halt_next;
        out_valid         <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      entry_valid  <= res_entry_valid;
      table_id     <= res_table_id;
      entry_index  <= res_entry_index;
      entry_value  <= res_entry_value;
      segment_done <= res_segment_done;
      error_code   <= res_error_code;
      halted       <= error_halt_next;
    end
  end

endmodule

`default_nettype wire

/* sv/jdqt_checker.sv */
// Port-level checks for the JPEG quantization-table segment parser.
`default_nettype none

module jdqt_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_valid,
  input wire logic                      in_stall,
  input wire logic                      command,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic                      entry_valid,
  input wire logic [jdqt_pkg::TID_W-1:0] table_id,
  input wire logic [jdqt_pkg::IDX_W-1:0] entry_index,
  input wire logic [15:0]               entry_value,
  input wire logic                      segment_done,
  input wire jdqt_pkg::err_t            error_code,
  input wire logic                      halted
);

  import jdqt_pkg::*;

  // A reported error always leaves the parser halted.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (error_code != ERR_NONE) |-> halted)
    else $error("error reported without halt");

  // Entries come only from a running parser without an error.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && entry_valid |-> !halted && (error_code == ERR_NONE))
    else $error("entry reported while halted or with an error");

  // A clear transfer yields an empty, running result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (command == CMD_CLEAR) |=>
      out_valid && !halted && !entry_valid && !segment_done &&
      (error_code == ERR_NONE))
    else $error("clear did not produce an empty result");

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(entry_valid) && $stable(entry_value) &&
      $stable(entry_index) && $stable(table_id) && $stable(halted))
    else $error("stalled result changed");

endmodule

bind jpeg_dqt_segment_parser jdqt_checker u_checker (.*);

`default_nettype wire

/* bench/jpeg_dqt_segment_parser_tb.sv */
// Self-checking testbench for the JPEG quantization-table segment parser.
`timescale 1ns / 100ps

module jpeg_dqt_segment_parser_tb;
  import jdqt_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  // Parser position within a segment, as tracked by the predictor.
  typedef enum logic [2:0] {
    AWAIT_LEN_HI,
    AWAIT_LEN_LO,
    AWAIT_HEADER,
    IN_ENTRIES,
    IN_SKIP
  } parse_phase_t;

  // One result transfer.
  typedef struct packed {
    logic             entry_valid;
    logic [TID_W-1:0] table_id;
    logic [IDX_W-1:0] entry_index;
    logic [15:0]      entry_value;
    logic             segment_done;
    err_t             error_code;
    logic             halted;
  } dqt_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  cmd_t             command = CMD_BYTE;
  logic [7:0]       data_byte = 8'h00;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             entry_valid;
  logic [TID_W-1:0] table_id;
  logic [IDX_W-1:0] entry_index;
  logic [15:0]      entry_value;
  logic             segment_done;
  err_t             error_code;
  logic             halted;

  // Predicted parser state.
  parse_phase_t pred_phase  = AWAIT_LEN_HI;
  logic [15:0]  pred_len    = '0;
  logic [15:0]  pred_count  = '0;
  logic [7:0]   pred_held   = '0;
  logic         pred_wide   = 1'b0;
  logic [1:0]   pred_table  = '0;
  logic [3:0]   pred_loaded = '0;
  logic         pred_halt   = 1'b0;

  dqt_result_t predicted_results[$];
  bit quiet      = 1'b0;
  bit hold_req   = 1'b0;
  int bytes_sent = 0;
  int fail_count = 0;
  int idle_cycles = 0;

  jpeg_dqt_segment_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_valid  (entry_valid),
    .table_id     (table_id),
    .entry_index  (entry_index),
    .entry_value  (entry_value),
    .segment_done (segment_done),
    .error_code   (error_code),
    .halted       (halted)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Ends the segment when the length is used up, otherwise moves on to skipping.
  function automatic logic reached_length();
    if (pred_count == pred_len) begin
      pred_phase = AWAIT_LEN_HI;
      return 1'b1;
    end
    pred_phase = IN_SKIP;
    return 1'b0;
  endfunction

  // Advances the predicted state by one accepted byte and returns its result.
  function automatic dqt_result_t parse_byte(cmd_t c, logic [7:0] b);
    dqt_result_t res;
    logic [3:0]  prec;
    logic [3:0]  dest;
    logic [15:0] pos;
    logic [15:0] last_pos;
    err_t        err;
    res = '0;
    res.error_code = ERR_NONE;
    if (c == CMD_CLEAR) begin
      pred_phase  = AWAIT_LEN_HI;
      pred_len    = '0;
      pred_count  = '0;
      pred_held   = '0;
      pred_wide   = 1'b0;
      pred_table  = '0;
      pred_loaded = '0;
      pred_halt   = 1'b0;
      return res;
    end
    if (pred_halt) begin
      res.halted = 1'b1;
      return res;
    end
    case (pred_phase)
      AWAIT_LEN_HI: begin
        pred_held  = b;
        pred_count = 16'd1;
        pred_phase = AWAIT_LEN_LO;
      end
      AWAIT_LEN_LO: begin
        pred_len   = {pred_held, b};
        pred_count = 16'd2;
        pred_phase = AWAIT_HEADER;
      end
      AWAIT_HEADER: begin
        prec = b[7:4];
        dest = b[3:0];
        err  = ERR_NONE;
        // Checks are taken in priority order; the first failing one wins.
        if (prec > 4'd1) begin
          err = ERR_PRECISION;
        end else if (dest >= 4'(NUM_TABLES)) begin
          err = ERR_DESTINATION;
        end else if (pred_loaded[dest[1:0]]) begin
          err = ERR_DUPLICATE;
        end else if (pred_len < (prec[0] ? NEED_WIDE : NEED_NARROW)) begin
          err = ERR_SHORT;
        end
        if (err != ERR_NONE) begin
          pred_halt = 1'b1;
          res.error_code = err;
        end else begin
          pred_loaded[dest[1:0]] = 1'b1;
          pred_wide  = prec[0];
          pred_table = dest[1:0];
          pred_count = 16'd3;
          pred_phase = IN_ENTRIES;
        end
      end
      IN_ENTRIES: begin
        pos      = pred_count - 16'd3;
        last_pos = pred_wide ? 16'(2 * TABLE_ENTRIES - 1) : 16'(TABLE_ENTRIES - 1);
        pred_count = pred_count + 16'd1;
        if (pred_wide && !pos[0]) begin
          pred_held = b;
        end else begin
          res.entry_valid = 1'b1;
          res.table_id    = pred_table;
          res.entry_index = pred_wide ? pos[IDX_W:1] : pos[IDX_W-1:0];
          res.entry_value = pred_wide ? {pred_held, b} : {8'h00, b};
        end
        if (pos >= last_pos) begin
          res.segment_done = reached_length();
        end
      end
      IN_SKIP: begin
        pred_count = pred_count + 16'd1;
        res.segment_done = reached_length();
      end
      default: begin
        pred_phase = AWAIT_LEN_HI;
      end
    endcase
    res.halted = pred_halt;
    return res;
  endfunction

  function automatic string fmt_result(dqt_result_t r);
    return $sformatf("ev=%0b tid=%0d idx=%0d val=%h done=%0b err=%0d halt=%0b",
                     r.entry_valid, r.table_id, r.entry_index, r.entry_value,
                     r.segment_done, r.error_code, r.halted);
  endfunction

  task automatic log_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
  endtask

  // Offers one byte or command, waits for its transfer and records the prediction.
  task automatic send_byte(cmd_t c, logic [7:0] b);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= c;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted_results.push_back(parse_byte(c, b));
    bytes_sent++;
  endtask

  task automatic send_clear();
    send_byte(CMD_CLEAR, 8'($urandom_range(0, 255)));
  endtask

  // Sends length, header and body_count body bytes. With extremes set the
  // body cycles through 00 00 FF FF 80 01, otherwise it is random.
  task automatic send_dqt_segment(logic [15:0] seg_length, logic [7:0] pq_tq,
                                  int body_count, bit extremes);
    logic [7:0] b;
    send_byte(CMD_BYTE, seg_length[15:8]);
    send_byte(CMD_BYTE, seg_length[7:0]);
    send_byte(CMD_BYTE, pq_tq);
    for (int i = 0; i < body_count; i++) begin
      if (extremes) begin
        case (i % 6)
          0, 1:    b = 8'h00;
          2, 3:    b = 8'hFF;
          4:       b = 8'h80;
          default: b = 8'h01;
        endcase
      end else begin
        b = 8'($urandom_range(0, 255));
      end
      send_byte(CMD_BYTE, b);
    end
  endtask

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    dqt_result_t got;
    dqt_result_t want;
    if (!rst && out_valid && !out_stall) begin
      got.entry_valid  = entry_valid;
      got.table_id     = table_id;
      got.entry_index  = entry_index;
      got.entry_value  = entry_value;
      got.segment_done = segment_done;
      got.error_code   = error_code;
      got.halted       = halted;
      if (predicted_results.size() == 0) begin
        log_failure({"result with nothing predicted: ", fmt_result(got)});
      end else begin
        want = predicted_results.pop_front();
        if (got.entry_valid !== want.entry_valid || got.table_id !== want.table_id ||
            got.entry_index !== want.entry_index || got.entry_value !== want.entry_value ||
            got.segment_done !== want.segment_done || got.error_code !== want.error_code ||
            got.halted !== want.halted) begin
          log_failure({"expected ", fmt_result(want), " got ", fmt_result(got)});
        end
      end
    end
  end

  // Watchdog: too many cycles without any transfer ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // An 8-bit table whose length is just the header plus the table ends on its last entry.
  task automatic test_narrow_exact_length();
    send_dqt_segment(NEED_NARROW, 8'h00, TABLE_ENTRIES, 1'b1);
  endtask

  // A 16-bit table and an 8-bit table, both followed by bytes to skip.
  task automatic test_tables_with_skip();
    send_dqt_segment(NEED_WIDE + 16'd3, 8'h13, 2 * TABLE_ENTRIES + 3, 1'b1);
    send_dqt_segment(NEED_NARROW + 16'd12, 8'h02, TABLE_ENTRIES + 12, 1'b0);
  endtask

  // Every error code, the bytes ignored after it, and the clear that ends the halt.
  task automatic test_header_errors();
    send_dqt_segment(NEED_NARROW, 8'h00, 2, 1'b0);
    send_clear();
    send_dqt_segment(16'hFFFF, 8'hF7, 2, 1'b1);
    send_clear();
    send_dqt_segment(NEED_WIDE, 8'h14, 1, 1'b0);
    send_clear();
    send_dqt_segment(NEED_NARROW - 16'd1, 8'h01, 1, 1'b0);
    send_clear();
    send_dqt_segment(NEED_WIDE - 16'd1, 8'h12, 1, 1'b0);
    send_clear();
    send_dqt_segment(16'h0000, 8'h00, 0, 1'b0);
    send_clear();
  endtask

  // Clear in the middle of a table and right after the length high byte.
  task automatic test_clear_mid_segment();
    send_dqt_segment(NEED_NARROW, 8'h01, 10, 1'b0);
    send_clear();
    send_dqt_segment(NEED_NARROW, 8'h01, TABLE_ENTRIES, 1'b0);
    send_byte(CMD_BYTE, 8'h00);
    send_clear();
  endtask

  // The result side holds off for a long stretch while bytes keep coming.
  task automatic test_backpressure();
    send_clear();
    hold_req = 1'b1;
    send_dqt_segment(NEED_WIDE, 8'h11, 2 * TABLE_ENTRIES, 1'b0);
  endtask

  // Mostly well-formed segments with random content, plus broken ones and noise.
  task automatic test_random_segments(int byte_budget);
    int          stop_at;
    int          kind;
    logic [3:0]  prec;
    logic [1:0]  dest;
    logic [15:0] len;
    int          n;
    stop_at = bytes_sent + byte_budget;
    while (bytes_sent < stop_at) begin
      if (pred_halt || pred_phase != AWAIT_LEN_HI) send_clear();
      kind = $urandom_range(0, 9);
      prec = 4'($urandom_range(0, 1));
      len  = prec[0] ? NEED_WIDE : NEED_NARROW;
      if (kind <= 6) begin
        if (pred_loaded == 4'hF) send_clear();
        do dest = 2'($urandom_range(0, 3)); while (pred_loaded[dest]);
        len = len + 16'(($urandom_range(0, 5) == 0) ? $urandom_range(5, 20)
                                                    : $urandom_range(0, 2));
        send_dqt_segment(len, {prec, 2'b00, dest}, len - 3, 1'b0);
      end else if (kind == 7) begin
        // Random header and length, usually ending in an error.
        len = {7'b0, 9'($urandom_range(0, 511))};
        send_dqt_segment(len, 8'($urandom_range(0, 255)), $urandom_range(0, 8), 1'b0);
        if ($urandom_range(0, 1) == 1) send_clear();
      end else if (kind == 8) begin
        // A table cut short by a clear.
        dest = 2'($urandom_range(0, 3));
        send_dqt_segment(len, {prec, 2'b00, dest}, $urandom_range(0, len - 4), 1'b0);
        send_clear();
      end else begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          send_byte(($urandom_range(0, 7) == 0) ? CMD_CLEAR : CMD_BYTE,
                    8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_narrow_exact_length();
    test_tables_with_skip();
    test_header_errors();
    test_clear_mid_segment();
    test_backpressure();
    test_random_segments(80);
    // Closing stretch runs at full rate on both sides.
    quiet = 1'b1;
    test_random_segments(50);
    in_valid <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
